>>> design/mlrq_pkg.sv
// ----------------------------------------------------------------------------
// mlrq_pkg
// Shared constants, types and helpers for the multilevel ready queue.
// ----------------------------------------------------------------------------
package mlrq_pkg;

    localparam int NUM_LEVELS      = 8;
    localparam int SLOTS_PER_LEVEL = 16;
    localparam int ID_BITS         = 8;

    // Fixed field widths of the stream items
    localparam int CMD_W   = 2;
    localparam int IDENT_W = 8;
    localparam int LEVEL_W = 3;
    localparam int STAT_W  = 2;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 16;

    // Derived storage widths
    localparam int LVL_W   = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
    localparam int SLOT_W  = $clog2(SLOTS_PER_LEVEL);
    localparam int CNT_W   = $clog2(SLOTS_PER_LEVEL + 1);
    localparam int DEPTH   = NUM_LEVELS * SLOTS_PER_LEVEL;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int STORE_W = (ID_BITS < IDENT_W) ? ID_BITS : IDENT_W;

    typedef enum logic [CMD_W-1:0] {
        CMD_ENQUEUE = 2'd0,
        CMD_CHOOSE  = 2'd1,
        CMD_REMOVE  = 2'd2,
        CMD_NOP     = 2'd3
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOT_TAIL = 2'd3
    } status_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load_in;   // capture the accepted input beat
        logic look;      // resolve level, read queue memory
        logic exec;      // update queue state, load result register
    } ctl_t;

    // Position inside a ring; value is below twice the ring size
    function automatic logic [SLOT_W-1:0] wrap_pos(input logic [SLOT_W:0] p);
        logic [SLOT_W:0] q;
        q = (p >= (SLOT_W+1)'(SLOTS_PER_LEVEL)) ? p - (SLOT_W+1)'(SLOTS_PER_LEVEL) : p;
        return q[SLOT_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] slot_addr(input logic [LVL_W-1:0] lvl,
                                                     input logic [SLOT_W-1:0] pos);
        return ADDR_W'(int'(lvl) * SLOTS_PER_LEVEL + int'(pos));
    endfunction

    function automatic logic [LVL_W-1:0] lvl_idx(input logic [LEVEL_W-1:0] l);
        logic [4:0] w;
        w = {2'b00, l};
        return w[LVL_W-1:0];
    endfunction

endpackage

>>> design/mlrq_ctrl.sv
// ----------------------------------------------------------------------------
// mlrq_ctrl
// Sequencer for the ready queue: accept, look-up, execute, with a result
// register that frees the input side while a result waits downstream.
// ----------------------------------------------------------------------------
module mlrq_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  logic          m_tready,
    output mlrq_pkg::ctl_t ctl
);
    import mlrq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_LOOK = 3'b010,
        S_EXEC = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;
    logic   accept;
    logic   exec_fire;

    assign out_free  = !out_valid_reg || m_tready;
    assign s_tready  = (state_reg == S_IDLE) || ((state_reg == S_EXEC) && out_free);
    assign accept    = s_tvalid && s_tready;
    assign exec_fire = (state_reg == S_EXEC) && out_free;
    assign m_tvalid  = out_valid_reg;

    assign ctl.load_in = accept;
    assign ctl.look    = (state_reg == S_LOOK);
    assign ctl.exec    = exec_fire;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_LOOK;
            end
            S_LOOK:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (out_free)
                    state_next = accept ? S_LOOK : S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (exec_fire)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_accept_to_look: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == S_LOOK)
        else $error("accepted beat did not start a look-up");

    a_exec_after_look: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC) |-> ($past(state_reg) == S_LOOK || $past(state_reg) == S_EXEC))
        else $error("execute entered without a look-up");

    a_no_accept_in_look: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOOK) |-> !s_tready)
        else $error("input taken during look-up");

    a_exec_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
        exec_fire |=> out_valid_reg)
        else $error("executed item produced no result beat");

endmodule

>>> design/mlrq_datapath.sv
// ----------------------------------------------------------------------------
// mlrq_datapath
// Per-level head/count registers, the shared slot memory and the result
// register. Look-up picks the level and reads memory; execute writes back.
// ----------------------------------------------------------------------------
module mlrq_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  mlrq_pkg::ctl_t                  ctl,
    input  logic [mlrq_pkg::CMD_W-1:0]      in_cmd,
    input  logic [mlrq_pkg::IDENT_W-1:0]    in_ident,
    input  logic [mlrq_pkg::LEVEL_W-1:0]    in_level,
    output logic [mlrq_pkg::IDENT_W-1:0]    chosen_ident,
    output logic                            chosen_valid,
    output logic [mlrq_pkg::STAT_W-1:0]     status
);
    import mlrq_pkg::*;

    // Captured input beat
    cmd_t                cmd_reg;
    logic [STORE_W-1:0]  ident_reg;
    logic [LEVEL_W-1:0]  level_reg;

    // Queue state
    logic [SLOT_W-1:0]   head_reg  [NUM_LEVELS];
    logic [CNT_W-1:0]    count_reg [NUM_LEVELS];
    logic [STORE_W-1:0]  slot_mem_reg [DEPTH];

    // Look-up stage results
    logic [LVL_W-1:0]    sel_reg;
    logic                sel_ok_reg;
    logic [SLOT_W-1:0]   sel_head_reg;
    logic [CNT_W-1:0]    sel_count_reg;
    logic [STORE_W-1:0]  rd_data_reg;

    // Result register
    logic [IDENT_W-1:0]  res_ident_reg;
    logic                res_valid_reg;
    status_t             res_status_reg;

    logic                any_busy;
    logic [LVL_W-1:0]    pick;
    logic                lvl_ok;
    logic [LVL_W-1:0]    sel;
    logic                sel_ok;
    logic [SLOT_W-1:0]   head_cur;
    logic [CNT_W-1:0]    count_cur;
    logic [SLOT_W:0]     tail_sum;
    logic [ADDR_W-1:0]   rd_addr;

    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic [STORE_W-1:0]  wr_data;
    logic                head_upd;
    logic                count_upd;
    logic [SLOT_W-1:0]   head_new;
    logic [CNT_W-1:0]    count_new;
    logic [IDENT_W-1:0]  res_ident;
    logic                res_valid;
    status_t             res_status;
    logic [SLOT_W:0]     end_sum;

    // Highest-priority non-empty level
    always_comb
    begin
        any_busy = 1'b0;
        pick     = '0;
        for (int i = NUM_LEVELS - 1; i >= 0; i--)
        begin
            if (count_reg[i] != '0)
            begin
                any_busy = 1'b1;
                pick     = LVL_W'(i);
            end
        end
    end

    assign lvl_ok    = ({2'b00, level_reg} < 5'(NUM_LEVELS));
    assign sel       = (cmd_reg == CMD_CHOOSE) ? pick : lvl_idx(level_reg);
    assign sel_ok    = (cmd_reg == CMD_CHOOSE) ? any_busy : lvl_ok;
    assign head_cur  = head_reg[sel];
    assign count_cur = count_reg[sel];
    assign tail_sum  = (SLOT_W+1)'(head_cur) + (SLOT_W+1)'(count_cur) - (SLOT_W+1)'(1);

    // Choose reads the head slot, remove reads the tail slot
    always_comb
    begin
        if ((cmd_reg == CMD_REMOVE) && (count_cur != '0))
            rd_addr = slot_addr(sel, wrap_pos(tail_sum));
        else
            rd_addr = slot_addr(sel, head_cur);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_in)
        begin
            cmd_reg   <= cmd_t'(in_cmd);
            ident_reg <= in_ident[STORE_W-1:0];
            level_reg <= in_level;
        end
        if (ctl.look)
        begin
            sel_reg       <= sel;
            sel_ok_reg    <= sel_ok;
            sel_head_reg  <= head_cur;
            sel_count_reg <= count_cur;
        end
        if (ctl.exec)
        begin
            res_ident_reg  <= res_ident;
            res_valid_reg  <= res_valid;
            res_status_reg <= res_status;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            slot_mem_reg[wr_addr] <= wr_data;
        if (ctl.look)
            rd_data_reg <= slot_mem_reg[rd_addr];
    end

    // Execute: one slot write past the tail at most, plus head/count update
    assign end_sum = (SLOT_W+1)'(sel_head_reg) + (SLOT_W+1)'(sel_count_reg);

    always_comb
    begin
        wr_en      = 1'b0;
        wr_addr    = slot_addr(sel_reg, wrap_pos(end_sum));
        wr_data    = ident_reg;
        head_upd   = 1'b0;
        count_upd  = 1'b0;
        head_new   = wrap_pos((SLOT_W+1)'(sel_head_reg) + (SLOT_W+1)'(1));
        count_new  = sel_count_reg;
        res_ident  = '0;
        res_valid  = 1'b0;
        res_status = ST_OK;
        case (cmd_reg)
            CMD_ENQUEUE:
            begin
                if (!sel_ok_reg || (sel_count_reg == CNT_W'(SLOTS_PER_LEVEL)))
                    res_status = ST_FULL;
                else
                begin
                    wr_en     = 1'b1;
                    count_upd = 1'b1;
                    count_new = sel_count_reg + CNT_W'(1);
                end
            end
            CMD_CHOOSE:
            begin
                if (!sel_ok_reg)
                    res_status = ST_EMPTY;
                else
                begin
                    // old head is copied to the slot just past the tail
                    wr_en     = 1'b1;
                    wr_data   = rd_data_reg;
                    head_upd  = 1'b1;
                    res_ident = IDENT_W'(rd_data_reg);
                    res_valid = 1'b1;
                end
            end
            CMD_REMOVE:
            begin
                if (!sel_ok_reg || (sel_count_reg == '0))
                    res_status = ST_EMPTY;
                else if (rd_data_reg != ident_reg)
                    res_status = ST_NOT_TAIL;
                else
                begin
                    count_upd = 1'b1;
                    count_new = sel_count_reg - CNT_W'(1);
                end
            end
            default:
            begin
                res_status = ST_OK;
            end
        endcase
        if (!ctl.exec)
        begin
            wr_en     = 1'b0;
            head_upd  = 1'b0;
            count_upd = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_LEVELS; i++)
            begin
                head_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
        end
        else
        begin
            if (head_upd)
                head_reg[sel_reg] <= head_new;
            if (count_upd)
                count_reg[sel_reg] <= count_new;
        end
    end

    assign chosen_ident = res_ident_reg;
    assign chosen_valid = res_valid_reg;
    assign status       = res_status_reg;

endmodule

>>> design/multilevel_ready_queue_scheduler.sv
// ----------------------------------------------------------------------------
// multilevel_ready_queue_scheduler
// Per-priority task FIFOs with enqueue, round-robin choose and tail removal.
// ----------------------------------------------------------------------------
// Each command beat gives exactly one result beat. An item is worked in two
// steps: look-up resolves the level (priority search for choose) and reads
// the slot memory, then execute writes back and loads the result register.
// A new beat is taken in the execute step of the last one while the output
// register is free or being read. Results wait in an output register, which
// holds further execution only when it is still full. No clearing pass is
// needed after reset.
module multilevel_ready_queue_scheduler (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [7:0] task_ident, [10:8] level, rest zero
    input  logic [1:0]  s_tuser,    // [1:0] cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [7:0] chosen_ident, [9:8] status, rest zero
    output logic        m_tuser     // [0] chosen_valid
);
    import mlrq_pkg::*;

    ctl_t                ctl;
    logic [IDENT_W-1:0]  chosen_ident;
    logic                chosen_valid;
    logic [STAT_W-1:0]   status;

    mlrq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .ctl      (ctl)
    );

    mlrq_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .in_cmd       (s_tuser[CMD_W-1:0]),
        .in_ident     (s_tdata[IDENT_W-1:0]),
        .in_level     (s_tdata[IDENT_W+LEVEL_W-1:IDENT_W]),
        .chosen_ident (chosen_ident),
        .chosen_valid (chosen_valid),
        .status       (status)
    );

    assign m_tdata = {{(OUT_TDATA_W - IDENT_W - STAT_W){1'b0}}, status, chosen_ident};
    assign m_tuser = chosen_valid;

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stream-level check of the multilevel ready queue scheduler. A directed
// table covers empty, not-at-tail, duplicate ids and priority order; a long
// random run of enqueue bursts, choose runs and tail drains follows. Every result
// beat is checked against its typed-in result or a model of the per-level rings.
// ----------------------------------------------------------------------------
module tb;

    import mlrq_pkg::*;

    localparam int IDLE_LIMIT = 2000;
    localparam int RAND_ITEMS = 750;

    typedef struct packed {
        logic [7:0] ident;
        logic       valid;
        status_t    status;
    } sched_result_t;

    typedef struct packed {
        cmd_t          cmd;
        logic [7:0]    ident;
        logic [2:0]    level;
        logic          fixed;   // expected result typed in below
        sched_result_t res;
    } stim_row_t;

    localparam stim_row_t DIRECTED [23] = '{
        '{CMD_CHOOSE,  8'h00, 3'd0, 1'b1, '{8'h00, 1'b0, ST_EMPTY}},
        '{CMD_REMOVE,  8'h00, 3'd0, 1'b1, '{8'h00, 1'b0, ST_EMPTY}},
        '{CMD_REMOVE,  8'hFF, 3'd7, 1'b1, '{8'h00, 1'b0, ST_EMPTY}},
        '{CMD_NOP,     8'hFF, 3'd7, 1'b1, '{8'h00, 1'b0, ST_OK}},
        '{CMD_ENQUEUE, 8'hFF, 3'd7, 1'b1, '{8'h00, 1'b0, ST_OK}},
        '{CMD_ENQUEUE, 8'h00, 3'd7, 1'b1, '{8'h00, 1'b0, ST_OK}},
        '{CMD_CHOOSE,  8'h00, 3'd0, 1'b1, '{8'hFF, 1'b1, ST_OK}},
        '{CMD_CHOOSE,  8'hFF, 3'd7, 1'b1, '{8'h00, 1'b1, ST_OK}},
        '{CMD_REMOVE,  8'hFF, 3'd7, 1'b1, '{8'h00, 1'b0, ST_NOT_TAIL}},
        '{CMD_REMOVE,  8'h00, 3'd7, 1'b1, '{8'h00, 1'b0, ST_OK}},
        '{CMD_CHOOSE,  8'h00, 3'd0, 1'b1, '{8'hFF, 1'b1, ST_OK}},
        '{CMD_ENQUEUE, 8'hA5, 3'd0, 1'b1, '{8'h00, 1'b0, ST_OK}},
        '{CMD_ENQUEUE, 8'h5A, 3'd0, 1'b1, '{8'h00, 1'b0, ST_OK}},
        '{CMD_CHOOSE,  8'h00, 3'd0, 1'b1, '{8'hA5, 1'b1, ST_OK}},
        '{CMD_ENQUEUE, 8'h3C, 3'd3, 1'b1, '{8'h00, 1'b0, ST_OK}},
        '{CMD_ENQUEUE, 8'h3C, 3'd3, 1'b1, '{8'h00, 1'b0, ST_OK}},
        '{CMD_REMOVE,  8'h3C, 3'd3, 1'b1, '{8'h00, 1'b0, ST_OK}},
        '{CMD_REMOVE,  8'h3C, 3'd3, 1'b1, '{8'h00, 1'b0, ST_OK}},
        '{CMD_REMOVE,  8'h3C, 3'd3, 1'b1, '{8'h00, 1'b0, ST_EMPTY}},
        '{CMD_REMOVE,  8'h00, 3'd0, 1'b0, '{8'h00, 1'b0, ST_OK}},
        '{CMD_CHOOSE,  8'h81, 3'd5, 1'b0, '{8'h00, 1'b0, ST_OK}},
        '{CMD_NOP,     8'h00, 3'd0, 1'b1, '{8'h00, 1'b0, ST_OK}},
        '{CMD_ENQUEUE, 8'h81, 3'd4, 1'b0, '{8'h00, 1'b0, ST_OK}}
    };

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;     // [7:0] task_ident, [10:8] level
    logic [1:0]  s_tuser  = '0;     // [1:0] cmd
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;           // [7:0] chosen_ident, [9:8] status
    logic        m_tuser;           // [0] chosen_valid

    multilevel_ready_queue_scheduler DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Model of the ready queues
    logic [7:0]        ring_mem  [NUM_LEVELS][SLOTS_PER_LEVEL];
    logic [SLOT_W-1:0] ring_head [NUM_LEVELS] = '{default: '0};
    logic [CNT_W-1:0]  ring_fill [NUM_LEVELS] = '{default: '0};

    sched_result_t pending_results [$];
    int            errors      = 0;
    int            idle_cycles = 0;
    int            burst_left  = 0;
    bit            in_fire     = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic sched_result_t schedule_step(input cmd_t c, input logic [7:0] id,
                                                    input logic [2:0] lvl);
        sched_result_t r;
        int            l;
        int            pos;
        r = '{ident: 8'h00, valid: 1'b0, status: ST_OK};
        l = int'(lvl);
        case (c)
            CMD_ENQUEUE:
            begin
                if (l >= NUM_LEVELS || ring_fill[l] >= SLOTS_PER_LEVEL)
                    r.status = ST_FULL;
                else
                begin
                    pos = (int'(ring_head[l]) + int'(ring_fill[l])) % SLOTS_PER_LEVEL;
                    ring_mem[l][pos] = id;
                    ring_fill[l]++;
                end
            end
            CMD_CHOOSE:
            begin
                r.status = ST_EMPTY;
                for (l = 0; l < NUM_LEVELS && r.status == ST_EMPTY; l++)
                begin
                    if (ring_fill[l] != 0)
                    begin
                        r = '{ident: ring_mem[l][ring_head[l]], valid: 1'b1, status: ST_OK};
                        // head rotates to just past the tail
                        pos = (int'(ring_head[l]) + int'(ring_fill[l])) % SLOTS_PER_LEVEL;
                        ring_mem[l][pos] = r.ident;
                        ring_head[l] = SLOT_W'((int'(ring_head[l]) + 1) % SLOTS_PER_LEVEL);
                    end
                end
            end
            CMD_REMOVE:
            begin
                if (l >= NUM_LEVELS || ring_fill[l] == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    pos = (int'(ring_head[l]) + int'(ring_fill[l]) - 1) % SLOTS_PER_LEVEL;
                    if (ring_mem[l][pos] != id)
                        r.status = ST_NOT_TAIL;
                    else
                        ring_fill[l]--;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // Offer one beat, wait for it to be taken, then record what it should produce
    task automatic issue(input cmd_t c, input logic [7:0] id, input logic [2:0] lvl,
                         input logic fixed, input sched_result_t fixed_res);
        sched_result_t r;
        int            gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 16);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, lvl, id};
        s_tuser  <= c;
        do
            @(posedge clk);
        while (!in_fire);
        r = schedule_step(c, id, lvl);
        pending_results.push_back(fixed ? fixed_res : r);
    endtask

    // Sample both handshakes on the falling edge, ahead of the edge that takes them
    always @(negedge clk)
    begin
        sched_result_t want;
        sched_result_t got;
        bit            out_fire;
        in_fire  = rst_n && s_tvalid && s_tready;
        out_fire = rst_n && m_tvalid && m_tready;
        if (out_fire)
        begin
            got = '{ident: m_tdata[7:0], valid: m_tuser, status: status_t'(m_tdata[9:8])};
            if (pending_results.size() == 0)
            begin
                $display("%0t: result beat with nothing expected, got %h", $time, got);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.ident !== want.ident)
                begin
                    $display("%0t: chosen_ident expected %h actual %h",
                             $time, want.ident, got.ident);
                    errors++;
                end
                if (got.valid !== want.valid)
                begin
                    $display("%0t: chosen_valid expected %b actual %b",
                             $time, want.valid, got.valid);
                    errors++;
                end
                if (got.status !== want.status)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, got.status);
                    errors++;
                end
            end
        end
        if (!rst_n || in_fire || out_fire)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no beat moved for %0d cycles", $time, IDLE_LIMIT);
            $display("tb: done, errors");
            $finish;
        end
    end

    // Result side: stall patterns and random long hold-offs, one of them early on
    initial
    begin
        int seg;
        int span;
        int mode;
        seg = 0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (seg == 3 || $urandom_range(0, 39) == 0)
            begin
                span = (seg == 3) ? $urandom_range(250, 400) : $urandom_range(50, 300);
                m_tready <= 1'b0;
                repeat (span) @(posedge clk);
            end
            else
            begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(20, 150);
                repeat (span)
                begin
                    case (mode)
                        0:       m_tready <= 1'b1;
                        1:       m_tready <= 1'($urandom_range(0, 1));
                        2:       m_tready <= ($urandom_range(0, 3) == 0);
                        default: m_tready <= ($urandom_range(0, 7) != 0);
                    endcase
                    @(posedge clk);
                end
            end
            seg++;
        end
    end

    initial
    begin
        int         rand_items;
        int         pick;
        int         len;
        int         tail_pos;
        logic [2:0] lvl;
        logic [7:0] id;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[k])
            issue(DIRECTED[k].cmd, DIRECTED[k].ident, DIRECTED[k].level,
                  DIRECTED[k].fixed, DIRECTED[k].res);

        rand_items = 0;
        while (rand_items < RAND_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            len  = $urandom_range(1, 20);
            // half the time crowd the top levels so priority and full cases get hit
            lvl  = $urandom_range(0, 1) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(0, 2));
            if (pick < 30)
            begin
                repeat (len) issue(CMD_ENQUEUE, 8'($urandom_range(0, 255)), lvl, 1'b0, '0);
                rand_items += len;
            end
            else if (pick < 60)
            begin
                repeat (len) issue(CMD_CHOOSE, 8'($urandom_range(0, 255)),
                                   3'($urandom_range(0, 7)), 1'b0, '0);
                rand_items += len;
            end
            else if (pick < 85)
            begin
                repeat (len)
                begin
                    id = 8'($urandom_range(0, 255));
                    if (ring_fill[lvl] != 0 && $urandom_range(0, 9) != 0)
                    begin
                        tail_pos = (int'(ring_head[lvl]) + int'(ring_fill[lvl]) - 1)
                                   % SLOTS_PER_LEVEL;
                        id = ring_mem[lvl][tail_pos];
                    end
                    issue(CMD_REMOVE, id, lvl, 1'b0, '0);
                end
                rand_items += len;
            end
            else
            begin
                issue(cmd_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                      3'($urandom_range(0, 7)), 1'b0, '0);
                rand_items++;
            end
        end
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
